FILE: rtl/core/binary_max_heap_queue_assert.svh
// ----------------------------------------------------------------------------
// binary_max_heap_queue_assert.svh
// Assertion macros for the heap queue RTL; compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset
`define BMHQ_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: assertion failed");
// Check that a condition implies another in the next cycle
`define BMHQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define BMHQ_ASSERT_ALWAYS(label, clk, rstn, expr)
`define BMHQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types and codes shared by the heap queue controller, datapath and top level.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 11;

    // Operation codes
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEEK_TOP,
        ST_POP_TOP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_UP_RD,
        ST_UP_CMP,
        ST_FIN
    } state_t;

    // Read address selection
    typedef enum logic [1:0] {
        RD_TOP,
        RD_CHILD,
        RD_PARENT
    } rd_sel_t;

    // Write data selection
    typedef enum logic [1:0] {
        WR_VAL,
        WR_BIG,
        WR_PARENT
    } wr_sel_t;

    typedef struct packed {
        logic    start;
        logic    load_res;
        logic    pop_take;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    pos_to_big;
        logic    pos_to_parent;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
        logic pos_zero;
        logic left_in;
        logic val_lt_big;
        logic val_gt_parent;
    } sts_t;

endpackage

FILE: rtl/core/bmhq_dp.sv
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry memory, sift registers, comparators, result register.
// ----------------------------------------------------------------------------
module bmhq_dp
    import bmhq_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_payload,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_item_t m_payload
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = AW + 2;

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [1:0]               stat_reg, stat_next;
    out_item_t                out_reg, out_next;

    logic [AW-1:0]            addr_a, addr_b;
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;

    logic [IW-1:0]            l_idx, r_idx, count_ext;
    logic                     right_in, take_right;
    logic signed [DATA_W-1:0] big_val, wr_data;
    logic [AW-1:0]            big_idx, parent_idx;

    // Child and parent positions of the current hole
    assign l_idx      = {1'b0, pos_reg, 1'b1};
    assign r_idx      = l_idx + IW'(1);
    assign count_ext  = IW'(count_reg);
    assign right_in   = r_idx < count_ext;
    assign take_right = right_in && (rd_a_reg < rd_b_reg);
    assign big_val    = take_right ? rd_b_reg : rd_a_reg;
    assign big_idx    = take_right ? r_idx[AW-1:0] : l_idx[AW-1:0];
    assign parent_idx = (pos_reg - AW'(1)) >> 1;

    // Status toward the controller
    assign sts.empty         = (count_reg == '0);
    assign sts.full          = (count_reg >= CW'(CAPACITY));
    assign sts.one_left      = (count_reg == CW'(1));
    assign sts.pos_zero      = (pos_reg == '0);
    assign sts.left_in       = l_idx < count_ext;
    assign sts.val_lt_big    = val_reg < big_val;
    assign sts.val_gt_parent = rd_a_reg < val_reg;

    // Select read addresses
    always_comb begin
        case (cmd.rd_sel)
            RD_CHILD: begin
                addr_a = l_idx[AW-1:0];
                addr_b = r_idx[AW-1:0];
            end
            RD_PARENT: begin
                addr_a = parent_idx;
                addr_b = parent_idx;
            end
            default: begin
                addr_a = '0;
                addr_b = AW'(count_reg - CW'(1));
            end
        endcase
    end

    // Select write data; the write address is always the hole
    always_comb begin
        case (cmd.wr_sel)
            WR_BIG:    wr_data = big_val;
            WR_PARENT: wr_data = rd_a_reg;
            default:   wr_data = val_reg;
        endcase
    end

    // Entry memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[pos_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // Next values of the sift and result registers
    always_comb begin
        count_next = count_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        out_next   = out_reg;
        if (cmd.start) begin
            res_next  = '0;
            stat_next = STAT_OK;
            case (s_payload.kind)
                KIND_PUSH: begin
                    if (sts.full) begin
                        stat_next = STAT_FULL;
                    end else begin
                        val_next   = s_payload.value;
                        pos_next   = AW'(count_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                KIND_POP, KIND_PEEK: begin
                    if (sts.empty) begin
                        stat_next = STAT_EMPTY;
                    end
                end
                default: begin
                    stat_next = STAT_OK;
                end
            endcase
        end
        if (cmd.load_res) begin
            res_next = rd_a_reg;
        end
        if (cmd.pop_take) begin
            count_next = count_reg - CW'(1);
            val_next   = rd_b_reg;
            pos_next   = '0;
        end
        if (cmd.pos_to_big) begin
            pos_next = big_idx;
        end
        if (cmd.pos_to_parent) begin
            pos_next = parent_idx;
        end
        if (cmd.load_out) begin
            out_next.result_value = res_reg;
            out_next.status       = stat_reg;
            out_next.occupancy    = OCC_W'(count_reg);
        end
    end

    // Clear the entry count on reset; payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
        out_reg  <= out_next;
    end

    assign m_payload = out_reg;

endmodule

FILE: rtl/core/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Heap controller: sequences push, pop and peek over the datapath.
// ----------------------------------------------------------------------------
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    output logic       m_valid,
    input  logic       m_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        KIND_PUSH: state_next = sts.full ? ST_FIN : ST_UP_RD;
                        KIND_POP:  state_next = sts.empty ? ST_FIN : ST_POP_TOP;
                        KIND_PEEK: state_next = sts.empty ? ST_FIN : ST_PEEK_TOP;
                        default:   state_next = ST_FIN;
                    endcase
                end
            end
            ST_PEEK_TOP: state_next = ST_FIN;
            ST_POP_TOP:  state_next = sts.one_left ? ST_FIN : ST_DN_RD;
            ST_DN_RD:    state_next = ST_DN_CMP;
            ST_DN_CMP: begin
                if (sts.left_in && sts.val_lt_big) begin
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_UP_RD:    state_next = sts.pos_zero ? ST_FIN : ST_UP_CMP;
            ST_UP_CMP:   state_next = sts.val_gt_parent ? ST_UP_RD : ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd     = '0;
        cmd.rd_sel = RD_TOP;
        cmd.wr_sel = WR_VAL;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            ST_PEEK_TOP: begin
                cmd.load_res = 1'b1;
            end
            ST_POP_TOP: begin
                cmd.load_res = 1'b1;
                cmd.pop_take = 1'b1;
            end
            ST_DN_RD: begin
                cmd.rd_sel = RD_CHILD;
            end
            ST_DN_CMP: begin
                cmd.wr_en = 1'b1;
                if (sts.left_in && sts.val_lt_big) begin
                    cmd.wr_sel     = WR_BIG;
                    cmd.pos_to_big = 1'b1;
                end
            end
            ST_UP_RD: begin
                cmd.rd_sel = RD_PARENT;
                cmd.wr_en  = sts.pos_zero;
            end
            ST_UP_CMP: begin
                cmd.wr_en = 1'b1;
                if (sts.val_gt_parent) begin
                    cmd.wr_sel        = WR_PARENT;
                    cmd.pos_to_parent = 1'b1;
                end
            end
            ST_FIN: begin
                cmd.load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Hold the result until taken
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/core/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Operation: one item at a time; push sifts the new entry up, pop moves the last
//   entry to the top and sifts it down, peek reads the top, and an error or unused
//   code goes straight to the finish state. A result not yet taken holds the next
//   item in its finish state.
// Reset: aresetn (synchronous, active low) empties the heap; memory is kept.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

`include "binary_max_heap_queue_assert.svh"

    cmd_t cmd;
    sts_t sts;

    // Sequence the operations
    bmhq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_payload.kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Store and compare entries
    bmhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_payload (m_payload)
    );

    // An accepted item blocks the input until it is finished
    `BMHQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A child only moves up when it lies inside the heap
    `BMHQ_ASSERT_ALWAYS(a_big_in_heap, aclk, aresetn, !cmd.pos_to_big || sts.left_in)
    // No memory write while the result is loaded
    `BMHQ_ASSERT_ALWAYS(a_no_wr_on_out, aclk, aresetn, !(cmd.wr_en && cmd.load_out))

endmodule
